@@ src/pcf_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants of the PWM pulse capture framer.
// ---------------------------------------------------------------------------
package pcf_pkg;

  // number of servo channels
  localparam int CHANNELS = 5;

  // fixed field widths
  localparam int CH_FIELD_W = 3;
  localparam int TS_W       = 32;
  localparam int WIDTH_W    = 16;
  localparam int TYPE_W     = 8;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // channel index into the per channel arrays
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_FIELD_W:0] CH_LIMIT = (CH_FIELD_W + 1)'(CHANNELS);

  // frame layout: start, type, two bytes per channel, check, end
  localparam int FRAME_LEN = 4 + 2 * CHANNELS;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] IDX_START = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_TYPE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_DATA  = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_CHECK = IDX_W'(FRAME_LEN - 2);
  localparam logic [IDX_W-1:0] IDX_END   = IDX_W'(FRAME_LEN - 1);

  localparam logic [BYTE_W-1:0] FRAME_START = 8'hAA;
  localparam logic [BYTE_W-1:0] FRAME_END   = 8'h55;

  // register reset values
  localparam logic [TYPE_W-1:0]  PACKET_TYPE_RST = 8'd2;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST   = 16'd800;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST   = 16'd2200;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PACKET_TYPE = 2'd0,
    CFG_MIN_WIDTH   = 2'd1,
    CFG_MAX_WIDTH   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  packet_type;
    logic [WIDTH_W-1:0] min_width;
    logic [WIDTH_W-1:0] max_width;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    CMD_RISE = 2'd0,
    CMD_FALL = 2'd1,
    CMD_SEND = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [CH_IDX_W-1:0]   ch;
    logic [TS_W-1:0]       ts;
  } cmd_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SEND = 1'b1
  } back_state_t;

endpackage

@@ src/pcf_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcf_if
// Handshake channels of the PWM pulse capture framer: edge and send
// requests in, frame bytes out, register writes.
// ---------------------------------------------------------------------------
interface pcf_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [2:0]  channel;
  logic        pin_level;
  logic [31:0] timestamp_us;

  modport source (output valid, req_type, channel, pin_level, timestamp_us, input ready);
  modport sink   (input valid, req_type, channel, pin_level, timestamp_us, output ready);
endinterface

interface pcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface pcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/pwm_pulse_capture_framer.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwm_pulse_capture_framer
// Servo PWM pulse width capture on several channels with serial framing.
// ---------------------------------------------------------------------------
// Edge words record a rise time or measure a pulse width against the
// min/max window; send words produce a frame of 0xAA, type, two bytes per
// channel high first, an XOR check byte and 0x55 flagged as last. A two-word
// queue separates the accepting front from the executing back end. An edge
// word is executed when the back end pops it; a send word starts a frame of
// 14 bytes with five channels, paced by the single output register and the
// downstream ready. Registers are written on the cfg channel at any time it
// is idle and are always ready.
module pwm_pulse_capture_framer
  import pcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  pcf_in_if.sink     in_chan,
  pcf_out_if.source  out_chan,
  pcf_cfg_if.sink    cfg_chan
);

  cfg_regs_t cfg_r, cfg_nxt;
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;

  // configuration registers
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_PACKET_TYPE: cfg_nxt.packet_type = cfg_chan.data[TYPE_W-1:0];
        CFG_MIN_WIDTH:   cfg_nxt.min_width   = cfg_chan.data[WIDTH_W-1:0];
        CFG_MAX_WIDTH:   cfg_nxt.max_width   = cfg_chan.data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.packet_type <= PACKET_TYPE_RST;
      cfg_r.min_width   <= MIN_WIDTH_RST;
      cfg_r.max_width   <= MAX_WIDTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // request classification and queue
  pcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // command execution and framing
  pcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_chan  (out_chan)
  );

endmodule

@@ src/pcf_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcf_front
// Accepts request words, classifies them into rise, fall or send commands,
// drops edges of unknown channels and queues the rest for the back end.
// ---------------------------------------------------------------------------
module pcf_front
  import pcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  pcf_in_if.sink     in_chan,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              accept;
  logic              keep;
  logic              push;
  cmd_t              cmd_in;

  // classify the incoming word
  always_comb begin
    cmd_in.ch = in_chan.channel[CH_IDX_W-1:0];
    cmd_in.ts = in_chan.timestamp_us;
    if (in_chan.req_type) begin
      cmd_in.kind = CMD_SEND;
    end else if (in_chan.pin_level) begin
      cmd_in.kind = CMD_RISE;
    end else begin
      cmd_in.kind = CMD_FALL;
    end
  end

  assign in_chan.ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign accept        = in_chan.valid && in_chan.ready;
  assign keep          = in_chan.req_type || ({1'b0, in_chan.channel} < CH_LIMIT);
  assign push          = accept && keep;

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (cmd_pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

endmodule

@@ src/pcf_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcf_back
// Executes queued commands: records rise times, measures and filters pulse
// widths, and serializes frames one byte per cycle into an output register unless stalled.
// ---------------------------------------------------------------------------
module pcf_back
  import pcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_regs_t  cfg,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  pcf_out_if.source  out_chan
);

  back_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [BYTE_W-1:0]  check_r, check_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;
  logic [TS_W-1:0]    rise_time_r [CHANNELS];
  logic [WIDTH_W-1:0] pulse_width_r [CHANNELS];
  logic               rise_we;
  logic               width_we;
  logic [TS_W-1:0]    width_full;
  logic               in_window;
  logic [IDX_W-1:0]   wsel;
  logic [CH_IDX_W-1:0] wch;
  logic [WIDTH_W-1:0] wval;
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_is_data;

  // pulse width measurement and window check
  assign width_full = cmd.ts - rise_time_r[cmd.ch];
  assign in_window  = (width_full[TS_W-1:WIDTH_W] == '0)
                   && (width_full[WIDTH_W-1:0] >= cfg.min_width)
                   && (width_full[WIDTH_W-1:0] <= cfg.max_width);

  // frame byte selection
  assign wsel = idx_r - IDX_DATA;
  assign wch  = wsel[CH_IDX_W:1];
  assign wval = pulse_width_r[wch];

  always_comb begin
    cur_is_data = 1'b0;
    priority if (idx_r == IDX_START) begin
      cur_byte = FRAME_START;
    end else if (idx_r == IDX_TYPE) begin
      cur_byte = cfg.packet_type;
    end else if (idx_r == IDX_CHECK) begin
      cur_byte = check_r;
    end else if (idx_r == IDX_END) begin
      cur_byte = FRAME_END;
    end else begin
      cur_is_data = 1'b1;
      cur_byte    = wsel[0] ? wval[BYTE_W-1:0] : wval[WIDTH_W-1:BYTE_W];
    end
  end

  // command execution and frame sequencing
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    check_nxt     = check_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    rise_we       = 1'b0;
    width_we      = 1'b0;
    cmd_pop       = 1'b0;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_RISE: rise_we = 1'b1;
            CMD_FALL: width_we = in_window;
            CMD_SEND: begin
              state_nxt = BK_SEND;
              idx_nxt   = IDX_START;
              check_nxt = cfg.packet_type;
            end
            default: ;
          endcase
        end
      end
      BK_SEND: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = cur_byte;
          out_last_nxt  = (idx_r == IDX_END);
          idx_nxt       = idx_r + IDX_W'(1);
          if (cur_is_data) begin
            check_nxt = check_r ^ cur_byte;
          end
          if (idx_r == IDX_END) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    check_r    <= check_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // per channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rise_time_r[i]   <= '0;
        pulse_width_r[i] <= '0;
      end
    end else begin
      if (rise_we) begin
        rise_time_r[cmd.ch] <= cmd.ts;
      end
      if (width_we) begin
        pulse_width_r[cmd.ch] <= width_full[WIDTH_W-1:0];
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.frame_byte = out_byte_r;
  assign out_chan.last_byte  = out_last_r;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the PWM pulse capture framer.
// ---------------------------------------------------------------------------
// Edge and send words go in through a queue-fed driver with random gaps, and
// frame bytes come back under random backpressure. A local copy of the rise
// times, held widths and registers works out every frame. Each byte taken
// from the block is checked against the oldest byte still owed. Register
// writes happen only once the block has gone quiet. The window settings run
// from the reset values to the full range, a single value, an empty window
// and a zero window.
// ---------------------------------------------------------------------------
module testbench;
  import pcf_pkg::*;

  // word codes and framing constants
  localparam logic       REQ_EDGE      = 1'b0;
  localparam logic       REQ_SEND      = 1'b1;
  localparam logic       LVL_FALL      = 1'b0;
  localparam logic       LVL_RISE      = 1'b1;
  localparam logic [7:0] SOF_BYTE      = 8'hAA;
  localparam logic [7:0] EOF_BYTE      = 8'h55;
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [7:0]  TYPE_AT_RESET = 8'd2;
  localparam logic [15:0] LO_AT_RESET   = 16'd800;
  localparam logic [15:0] HI_AT_RESET   = 16'd2200;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_WAIT      = 18;

  typedef enum logic [1:0] {
    ACT_WORD  = 2'd0,
    ACT_CFG   = 2'd1,
    ACT_DRAIN = 2'd2
  } plan_kind_t;

  typedef struct {
    plan_kind_t  kind;
    logic        req;
    logic [2:0]  ch;
    logic        lvl;
    logic [31:0] ts;
    logic [1:0]  idx;
    logic [15:0] data;
  } plan_step_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic clk;
  logic rst_n;

  pcf_in_if  in_ch ();
  pcf_out_if out_ch ();
  pcf_cfg_if cfg_ch ();

  pwm_pulse_capture_framer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  plan_step_t  pending_words[$];
  frame_byte_t frame_expect[$];

  // mirror of the capture state and registers
  logic [31:0] rise_stamp [CHANNELS];
  logic [15:0] held_width [CHANNELS];
  logic [7:0]  cur_type;
  logic [15:0] win_lo;
  logic [15:0] win_hi;

  logic in_took;
  logic cfg_took;
  logic out_took;
  int   mismatch_count = 0;

  int gap_left    = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit in_quiet    = 1'b0;
  bit out_quiet   = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task automatic add_word(input logic req, input logic [2:0] ch, input logic lvl,
                          input logic [31:0] ts);
    plan_step_t s;
    s = '{kind: ACT_WORD, req: req, ch: ch, lvl: lvl, ts: ts, idx: '0, data: '0};
    pending_words.push_back(s);
  endtask

  task automatic add_send();
    add_word(REQ_SEND, 3'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [15:0] data);
    plan_step_t s;
    s = '{kind: ACT_CFG, req: 1'b0, ch: '0, lvl: 1'b0, ts: '0, idx: idx, data: data};
    pending_words.push_back(s);
  endtask

  task automatic add_drain();
    plan_step_t s;
    s = '{kind: ACT_DRAIN, req: 1'b0, ch: '0, lvl: 1'b0, ts: '0, idx: '0, data: '0};
    pending_words.push_back(s);
  endtask

  // wait for quiet, then program all three registers
  task automatic set_window(input logic [15:0] type_data, input logic [15:0] lo,
                            input logic [15:0] hi);
    add_drain();
    add_cfg(CFG_PACKET_TYPE, type_data);
    add_cfg(CFG_MIN_WIDTH, lo);
    add_cfg(CFG_MAX_WIDTH, hi);
  endtask

  // pulse width mostly inside the window, sometimes on or just past its bounds
  function automatic logic [31:0] pick_width(input logic [15:0] lo, input logic [15:0] hi);
    int          sel;
    logic [31:0] l32;
    logic [31:0] h32;
    sel = $urandom_range(0, 9);
    l32 = {16'd0, lo};
    h32 = {16'd0, hi};
    if (sel < 5 && lo <= hi) return $urandom_range(h32, l32);
    case (sel)
      5: return l32 - 1;
      6: return l32;
      7: return h32;
      8: return h32 + 1;
      default: return $urandom_range(0, 1) ? $urandom_range(0, 70000) : $urandom;
    endcase
  endfunction

  // mostly complete rise/fall pairs, plus sends, stray edges and pauses
  task automatic add_random(input int count, input logic [15:0] lo, input logic [15:0] hi);
    int          made;
    int          pick;
    logic [2:0]  ch;
    logic [31:0] t0;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        add_send();
        made++;
      end else if (pick < 75) begin
        ch = 3'($urandom_range(0, CHANNELS - 1));
        t0 = $urandom;
        add_word(REQ_EDGE, ch, LVL_RISE, t0);
        add_word(REQ_EDGE, ch, LVL_FALL, t0 + pick_width(lo, hi));
        made += 2;
      end else if (pick < 92) begin
        add_word(REQ_EDGE, 3'($urandom_range(0, 7)), 1'($urandom), $urandom);
        made++;
      end else if (pick < 97) begin
        add_word(REQ_EDGE, 3'($urandom_range(CHANNELS, 7)), 1'($urandom), $urandom);
      end else begin
        add_drain();
      end
    end
  endtask

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  task automatic predict_frame(input logic req, input logic [2:0] ch, input logic lvl,
                               input logic [31:0] ts);
    logic [31:0] span;
    logic [7:0]  chk;
    logic [7:0]  hi_b;
    logic [7:0]  lo_b;
    if (req == REQ_EDGE) begin
      // edges on missing channels are dropped
      if (ch < CHANNELS) begin
        if (lvl == LVL_RISE) begin
          rise_stamp[ch] = ts;
        end else begin
          span = ts - rise_stamp[ch];
          if (span >= {16'd0, win_lo} && span <= {16'd0, win_hi}) held_width[ch] = span[15:0];
        end
      end
    end else begin
      frame_expect.push_back('{data: SOF_BYTE, last: 1'b0});
      frame_expect.push_back('{data: cur_type, last: 1'b0});
      chk = cur_type;
      for (int i = 0; i < CHANNELS; i++) begin
        hi_b = held_width[i][15:8];
        lo_b = held_width[i][7:0];
        frame_expect.push_back('{data: hi_b, last: 1'b0});
        frame_expect.push_back('{data: lo_b, last: 1'b0});
        chk = chk ^ hi_b ^ lo_b;
      end
      frame_expect.push_back('{data: chk, last: 1'b0});
      frame_expect.push_back('{data: EOF_BYTE, last: 1'b1});
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: handshakes, register mirror and byte checks at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    frame_byte_t want;
    if (!rst_n) begin
      in_took  <= 1'b0;
      cfg_took <= 1'b0;
      out_took <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        rise_stamp[i] = '0;
        held_width[i] = '0;
      end
      cur_type = TYPE_AT_RESET;
      win_lo   = LO_AT_RESET;
      win_hi   = HI_AT_RESET;
    end else begin
      in_took  <= in_ch.valid && in_ch.ready;
      cfg_took <= cfg_ch.valid && cfg_ch.ready;
      out_took <= out_ch.valid && out_ch.ready;

      // frame byte against the oldest one owed
      if (out_ch.valid && out_ch.ready) begin
        if (frame_expect.size() == 0) begin
          $error("frame_byte: expected none, got %02h (last_byte %0b)",
                 out_ch.frame_byte, out_ch.last_byte);
          mismatch_count++;
        end else begin
          want = frame_expect.pop_front();
          if (out_ch.frame_byte !== want.data) begin
            $error("frame_byte: expected %02h, got %02h", want.data, out_ch.frame_byte);
            mismatch_count++;
          end
          if (out_ch.last_byte !== want.last) begin
            $error("last_byte: expected %0b, got %0b", want.last, out_ch.last_byte);
            mismatch_count++;
          end
        end
      end

      // register write
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_PACKET_TYPE: cur_type = cfg_ch.data[7:0];
          CFG_MIN_WIDTH:   win_lo   = cfg_ch.data;
          CFG_MAX_WIDTH:   win_hi   = cfg_ch.data;
          default: ;
        endcase
      end

      // accepted request word
      if (in_ch.valid && in_ch.ready)
        predict_frame(in_ch.req_type, in_ch.channel, in_ch.pin_level, in_ch.timestamp_us);
    end
  end

  // ---------------------------------------------------------------------------
  // driver: request and register words at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_words
    plan_step_t act;
    logic       in_v;
    logic       cfg_v;
    if (rst_n) begin
      in_v  = in_ch.valid && !in_took;
      cfg_v = cfg_ch.valid && !cfg_took;
      if (!in_v && !cfg_v && pending_words.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          act = pending_words[0];
          case (act.kind)
            ACT_WORD: begin
              void'(pending_words.pop_front());
              in_ch.req_type     <= act.req;
              in_ch.channel      <= act.ch;
              in_ch.pin_level    <= act.lvl;
              in_ch.timestamp_us <= act.ts;
              in_v = 1'b1;
              if ($urandom_range(0, 29) == 0) in_quiet = !in_quiet;
              gap_left = draw_wait(in_quiet);
            end
            ACT_CFG: begin
              void'(pending_words.pop_front());
              cfg_ch.index <= act.idx;
              cfg_ch.data  <= act.data;
              cfg_v = 1'b1;
            end
            default: begin
              // hold off until every byte is out and the back end has settled
              if (frame_expect.size() != 0) begin
                idle_cycles = 0;
              end else if (idle_cycles >= SETTLE_CYCLES) begin
                idle_cycles = 0;
                void'(pending_words.pop_front());
              end else begin
                idle_cycles++;
              end
            end
          endcase
        end
      end
      in_ch.valid  <= in_v;
      cfg_ch.valid <= cfg_v;
    end
  end

  // receiver backpressure, a fresh stall length drawn after every byte
  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (out_took) begin
        if ($urandom_range(0, 29) == 0) out_quiet = !out_quiet;
        stall_left = draw_wait(out_quiet);
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_plan
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_EDGE;
    in_ch.channel      = '0;
    in_ch.pin_level    = LVL_FALL;
    in_ch.timestamp_us = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_PACKET_TYPE;
    cfg_ch.data        = '0;

    // directed words under the reset window 800..2200
    add_word(REQ_SEND, 3'd0, LVL_FALL, 32'd0);
    add_word(REQ_EDGE, 3'd0, LVL_FALL, 32'd1000);          // fall with no rise
    add_word(REQ_EDGE, 3'd1, LVL_RISE, 32'hFFFF_FF00);
    add_word(REQ_EDGE, 3'd1, LVL_FALL, 32'h0000_03E8);     // wraps past zero
    add_word(REQ_EDGE, 3'd2, LVL_RISE, 32'd5000);
    add_word(REQ_EDGE, 3'd2, LVL_FALL, 32'd5800);          // on the low bound
    add_word(REQ_EDGE, 3'd3, LVL_RISE, 32'd100);
    add_word(REQ_EDGE, 3'd3, LVL_FALL, 32'd2300);          // on the high bound
    add_word(REQ_EDGE, 3'd4, LVL_RISE, 32'd0);
    add_word(REQ_EDGE, 3'd4, LVL_FALL, 32'd799);           // just short
    add_word(REQ_EDGE, 3'd4, LVL_RISE, 32'd10);
    add_word(REQ_EDGE, 3'd4, LVL_FALL, 32'd2211);          // just long
    add_word(REQ_SEND, 3'd0, LVL_FALL, 32'd0);
    add_word(REQ_EDGE, 3'd0, LVL_RISE, 32'hFFFF_FFFF);
    add_word(REQ_EDGE, 3'd0, LVL_FALL, 32'h0000_04AF);
    add_word(REQ_EDGE, 3'd5, LVL_RISE, 32'd0);             // missing channels
    add_word(REQ_EDGE, 3'd5, LVL_FALL, 32'd1000);
    add_word(REQ_EDGE, 3'd7, LVL_RISE, 32'hFFFF_FFFF);
    add_word(REQ_EDGE, 3'd6, LVL_FALL, 32'd1500);
    add_word(REQ_EDGE, 3'd4, LVL_FALL, 32'hFFFF_FFFF);
    add_word(REQ_SEND, 3'd7, LVL_RISE, 32'hFFFF_FFFF);     // unused fields set
    add_drain();
    add_word(REQ_SEND, 3'd0, LVL_FALL, 32'd0);

    // random phases over several register settings
    add_random(40, LO_AT_RESET, HI_AT_RESET);
    set_window(16'hFFFF, 16'h0000, 16'hFFFF);
    add_random(40, 16'h0000, 16'hFFFF);
    set_window(16'hA500, 16'hFFFF, 16'hFFFF);
    add_cfg(CFG_SPARE_IDX, 16'h1234);
    add_word(REQ_EDGE, 3'd2, LVL_RISE, 32'hFFFF_8000);
    add_word(REQ_EDGE, 3'd2, LVL_FALL, 32'h0000_7FFF);     // widest width
    add_random(40, 16'hFFFF, 16'hFFFF);
    set_window(16'h005A, 16'd3000, 16'd1000);              // empty window
    add_random(40, 16'd3000, 16'd1000);
    set_window(16'h0081, 16'd0, 16'd0);
    add_random(30, 16'd0, 16'd0);
    set_window({8'h00, TYPE_AT_RESET}, LO_AT_RESET, HI_AT_RESET);
    add_random(30, LO_AT_RESET, HI_AT_RESET);
    add_drain();

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for the plan to run out and every byte to arrive
    while (pending_words.size() != 0) @(posedge clk);
    while (frame_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #(20_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
